// ----- rtl/gcso_pkg.sv -----
// ----------------------------------------------------------------------------
// gcso_pkg: shared types and constants for the grid corner scan order block
// Sizes of the point store, coordinate format and the queue entry type.
// ----------------------------------------------------------------------------
package gcso_pkg;

    localparam int MAX_POINTS       = 64;
    localparam int COORD_BITS       = 32;
    localparam int INPUT_COORD_BITS = 32;
    localparam int INDEX_BITS       = $clog2(MAX_POINTS);
    localparam int COUNT_BITS       = $clog2(MAX_POINTS + 1);
    localparam int ORDER_INDEX_BITS = 6;
    localparam int ROW_LEN_BITS     = 5;
    localparam int ROW_POS_BITS     = 4;
    localparam int ROW_POS_LIMIT    = 16;
    localparam int ROW_LEN_RESET    = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [ORDER_INDEX_BITS-1:0]  order_index_t;
    typedef logic [ROW_LEN_BITS-1:0]      row_len_t;
    typedef logic [ROW_POS_BITS-1:0]      row_pos_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        coord_t x;
        coord_t y;
        index_t slot;     // store address given by the front
        logic   store;    // 0 when the store was already full
        logic   order;    // item closes the set: run the ordering
    } cmd_t;

endpackage

// ----- rtl/grid_corner_scan_order.sv -----
// ----------------------------------------------------------------------------
// grid_corner_scan_order: orders a set of corner points into grid scan order
// Collects Q16.16 points, then emits their load indices row by row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (point_valid / point_stall): one point item per accept,
//   point_x and point_y signed Q16.16. Items with last_point low are stored;
//   the item with last_point high is stored too (if there is room) and closes
//   the set. Up to 64 points per set; further points are dropped, but their
//   last_point still closes the set.
//   Output channel (order_valid / order_stall): one item per stored point,
//   order_index is the load position, last_index marks the final item.
//   The back end stores a point as it takes it from the queue. Ordering N
//   points runs one full scan of the point memory per pick, through the
//   single read port.
//   A two-entry queue sits between input and back end, so the input side
//   keeps accepting while the back end is busy until the queue fills.
//   The output register holds a result while order_stall is high; the back
//   end waits for it, and the queue then fills and raises point_stall.
//   cfg_write_en / cfg_write_data set row_length (reset 8); write it only
//   while the block is idle.
//   Reset empties the set and the queue; point memory contents are not
//   cleared, only slots written in the current set are ever read.
// ----------------------------------------------------------------------------
module grid_corner_scan_order (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [gcso_pkg::ROW_LEN_BITS-1:0]     cfg_write_data,
    input  logic                                  point_valid,
    output logic                                  point_stall,
    input  logic [gcso_pkg::INPUT_COORD_BITS-1:0] point_x,
    input  logic [gcso_pkg::INPUT_COORD_BITS-1:0] point_y,
    input  logic                                  last_point,
    output logic                                  order_valid,
    input  logic                                  order_stall,
    output logic [gcso_pkg::ORDER_INDEX_BITS-1:0] order_index,
    output logic                                  last_index
);

    // row length register
    gcso_pkg::row_len_t row_length_reg;
    gcso_pkg::row_len_t row_length_next;

    // front to queue
    logic           front_push;
    gcso_pkg::cmd_t front_cmd;

    // queue to back
    logic           queue_full;
    logic           queue_empty;
    logic           queue_pop;
    gcso_pkg::cmd_t head_cmd;

    assign row_length_next = cfg_write_en ? gcso_pkg::row_len_t'(cfg_write_data)
                                          : row_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_length_reg <= gcso_pkg::row_len_t'(gcso_pkg::ROW_LEN_RESET);
        else
            row_length_reg <= row_length_next;
    end

    // front: accepts point items and gives each a store slot
    gcso_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .queue_full  (queue_full),
        .push        (front_push),
        .cmd         (front_cmd)
    );

    gcso_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (queue_pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // back: point memory, pick sequencer and output register
    gcso_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_length  (row_length_reg),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (queue_pop),
        .order_valid (order_valid),
        .order_stall (order_stall),
        .order_index (order_index),
        .last_index  (last_index)
    );

endmodule

// ----- rtl/gcso_front.sv -----
// ----------------------------------------------------------------------------
// gcso_front: input side of the grid corner scan order block
// Accepts points, assigns store slots, drops points beyond capacity.
// ----------------------------------------------------------------------------
module gcso_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    point_valid,
    output logic                                    point_stall,
    input  logic [gcso_pkg::INPUT_COORD_BITS-1:0]   point_x,
    input  logic [gcso_pkg::INPUT_COORD_BITS-1:0]   point_y,
    input  logic                                    last_point,
    input  logic                                    queue_full,
    output logic                                    push,
    output gcso_pkg::cmd_t                          cmd
);

    gcso_pkg::count_t fill_reg;
    gcso_pkg::count_t fill_next;
    logic             has_room;

    assign point_stall = queue_full;
    assign push        = point_valid && !queue_full;
    assign has_room    = fill_reg < gcso_pkg::count_t'(gcso_pkg::MAX_POINTS);

    always_comb
    begin
        cmd.x     = gcso_pkg::coord_t'(point_x);
        cmd.y     = gcso_pkg::coord_t'(point_y);
        cmd.slot  = gcso_pkg::index_t'(fill_reg);
        cmd.store = has_room;
        cmd.order = last_point;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push)
        begin
            if (last_point)
                fill_next = '0;
            else if (has_room)
                fill_next = fill_reg + gcso_pkg::count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

// ----- rtl/gcso_queue.sv -----
// ----------------------------------------------------------------------------
// gcso_queue: two-entry queue between the front and the back
// Lets the input side keep taking items while the back is busy.
// ----------------------------------------------------------------------------
module gcso_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcso_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output gcso_pkg::cmd_t  head_cmd,
    output logic            full,
    output logic            empty
);

    gcso_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     used_reg;
    logic [1:0]     used_next;

    assign full     = used_reg == 2'd2;
    assign empty    = used_reg == 2'd0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        used_next   = used_reg;
        if (push)
            wr_ptr_next = !wr_ptr_reg;
        if (pop)
            rd_ptr_next = !rd_ptr_reg;
        if (push && !pop)
            used_next = used_reg + 2'd1;
        else if (pop && !push)
            used_next = used_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

endmodule

// ----- rtl/gcso_back.sv -----
// ----------------------------------------------------------------------------
// gcso_back: point store and ordering sequencer
// Writes points to memory, then picks them one scan at a time.
// ----------------------------------------------------------------------------
module gcso_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gcso_pkg::row_len_t             row_length,
    input  logic                           queue_empty,
    input  gcso_pkg::cmd_t                 head_cmd,
    output logic                           pop,
    output logic                           order_valid,
    input  logic                           order_stall,
    output logic [gcso_pkg::ORDER_INDEX_BITS-1:0] order_index,
    output logic                           last_index
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int WORD_BITS = 2 * gcso_pkg::COORD_BITS;

    logic [WORD_BITS-1:0] mem [gcso_pkg::MAX_POINTS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [1:0]                     state_reg,     state_next;
    gcso_pkg::count_t               count_reg,     count_next;
    gcso_pkg::count_t               done_reg,      done_next;
    gcso_pkg::count_t               rd_addr_reg,   rd_addr_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    gcso_pkg::index_t               cmp_idx_reg,   cmp_idx_next;
    logic [gcso_pkg::MAX_POINTS-1:0] taken_reg,    taken_next;
    logic                           found_reg,     found_next;
    logic                           any_left_reg,  any_left_next;
    gcso_pkg::index_t               best_idx_reg,  best_idx_next;
    gcso_pkg::coord_t               best_x_reg,    best_x_next;
    gcso_pkg::coord_t               best_y_reg,    best_y_next;
    gcso_pkg::index_t               first_idx_reg, first_idx_next;
    gcso_pkg::coord_t               first_y_reg,   first_y_next;
    gcso_pkg::coord_t               row_bound_reg, row_bound_next;
    gcso_pkg::row_pos_t             row_pos_reg,   row_pos_next;
    logic                           out_valid_reg, out_valid_next;
    gcso_pkg::order_index_t         out_index_reg, out_index_next;
    logic                           out_last_reg,  out_last_next;

    logic               mem_we;
    logic               issue;
    logic               eligible;
    logic               masked;
    gcso_pkg::coord_t   cand_x;
    gcso_pkg::coord_t   cand_y;
    gcso_pkg::index_t   pick_idx;
    gcso_pkg::coord_t   pick_y;
    gcso_pkg::row_len_t row_step;
    logic               run_done;
    logic               out_free;

    assign pop         = (state_reg == ST_LOAD) && !queue_empty;
    assign mem_we      = pop && head_cmd.store;
    assign issue       = (state_reg == ST_SCAN) && (rd_addr_reg < count_reg);
    assign cand_x      = gcso_pkg::coord_t'(rd_data_reg[WORD_BITS-1:gcso_pkg::COORD_BITS]);
    assign cand_y      = gcso_pkg::coord_t'(rd_data_reg[gcso_pkg::COORD_BITS-1:0]);
    assign eligible    = cmp_valid_reg && !taken_reg[cmp_idx_reg];
    assign masked      = (row_pos_reg != '0) && (cand_y <= row_bound_reg);
    assign pick_idx    = found_reg ? best_idx_reg : first_idx_reg;
    assign pick_y      = found_reg ? best_y_reg : first_y_reg;
    assign row_step    = gcso_pkg::row_len_t'(row_pos_reg) + gcso_pkg::row_len_t'(1);
    assign run_done    = (done_reg + gcso_pkg::count_t'(1)) == count_reg;
    assign out_free    = !out_valid_reg || !order_stall;

    assign order_valid = out_valid_reg;
    assign order_index = out_index_reg;
    assign last_index  = out_last_reg;

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[head_cmd.slot] <= {head_cmd.x, head_cmd.y};
        rd_data_reg <= mem[rd_addr_reg[gcso_pkg::INDEX_BITS-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        rd_addr_next   = rd_addr_reg;
        cmp_valid_next = issue;
        cmp_idx_next   = rd_addr_reg[gcso_pkg::INDEX_BITS-1:0];
        taken_next     = taken_reg;
        found_next     = found_reg;
        any_left_next  = any_left_reg;
        best_idx_next  = best_idx_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        first_idx_next = first_idx_reg;
        first_y_next   = first_y_reg;
        row_bound_next = row_bound_reg;
        row_pos_next   = row_pos_reg;
        out_valid_next = out_valid_reg && order_stall;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;

        // compare stage, one stored point per cycle
        if (eligible)
        begin
            if (!any_left_reg)
            begin
                any_left_next  = 1'b1;
                first_idx_next = cmp_idx_reg;
                first_y_next   = cand_y;
            end
            if (!masked && (!found_reg || (cand_x < best_x_reg)))
            begin
                found_next    = 1'b1;
                best_idx_next = cmp_idx_reg;
                best_x_next   = cand_x;
                best_y_next   = cand_y;
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    if (head_cmd.store)
                        count_next = gcso_pkg::count_t'(head_cmd.slot) + gcso_pkg::count_t'(1);
                    if (head_cmd.order)
                    begin
                        state_next    = ST_SCAN;
                        done_next     = '0;
                        rd_addr_next  = '0;
                        found_next    = 1'b0;
                        any_left_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                    rd_addr_next = rd_addr_reg + gcso_pkg::count_t'(1);
                else if (!cmp_valid_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = gcso_pkg::order_index_t'(pick_idx);
                    out_last_next  = run_done;
                    if (run_done)
                    begin
                        state_next     = ST_LOAD;
                        count_next     = '0;
                        taken_next     = '0;
                        row_bound_next = '0;
                        row_pos_next   = '0;
                    end
                    else
                    begin
                        state_next          = ST_SCAN;
                        done_next           = done_reg + gcso_pkg::count_t'(1);
                        taken_next[pick_idx] = 1'b1;
                        row_bound_next      = pick_y;
                        rd_addr_next        = '0;
                        found_next          = 1'b0;
                        any_left_next       = 1'b0;
                        if ((row_step >= row_length) ||
                            (row_step >= gcso_pkg::row_len_t'(gcso_pkg::ROW_POS_LIMIT)))
                            row_pos_next = '0;
                        else
                            row_pos_next = gcso_pkg::row_pos_t'(row_step);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            done_reg      <= '0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            taken_reg     <= '0;
            found_reg     <= 1'b0;
            any_left_reg  <= 1'b0;
            row_bound_reg <= '0;
            row_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            taken_reg     <= taken_next;
            found_reg     <= found_next;
            any_left_reg  <= any_left_next;
            row_bound_reg <= row_bound_next;
            row_pos_reg   <= row_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_x_reg    <= best_x_next;
        best_y_reg    <= best_y_next;
        first_idx_reg <= first_idx_next;
        first_y_reg   <= first_y_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ----- dv/tb_grid_corner_scan_order.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_corner_scan_order: self-checking bench for the corner scan order block
// Streams sets of Q16.16 corner points into the block and predicts the order
// of load indices for each set. Every result item is checked against that
// prediction. Runs several row lengths, and uses random idling on both sides
// and one long hold-off at the output.
// ----------------------------------------------------------------------------
module tb_grid_corner_scan_order;

    localparam int CYCLE_LIMIT   = 200000; // far above the slowest correct run
    localparam int SETTLE_CYCLES = 20;     // extra wait once all results are out
    localparam int TAIL_CYCLES   = 200;    // quiet time after the last result
    localparam int LONG_HOLD     = 300;    // output hold-off, in cycles
    localparam int PHASE_ITEMS   = 20;     // input items per random phase

    // One input item as queued for the driver.
    typedef struct {
        logic [gcso_pkg::INPUT_COORD_BITS-1:0] x;
        logic [gcso_pkg::INPUT_COORD_BITS-1:0] y;
        logic                                  last;
    } point_item_t;

    // One expected result item.
    typedef struct packed {
        gcso_pkg::order_index_t idx;
        logic                   closes;
    } scan_pick_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write_en;
    logic [gcso_pkg::ROW_LEN_BITS-1:0]     cfg_write_data;
    logic                                  point_valid;
    logic                                  point_stall;
    logic [gcso_pkg::INPUT_COORD_BITS-1:0] point_x;
    logic [gcso_pkg::INPUT_COORD_BITS-1:0] point_y;
    logic                                  last_point;
    logic                                  order_valid;
    logic                                  order_stall;
    logic [gcso_pkg::ORDER_INDEX_BITS-1:0] order_index;
    logic                                  last_index;

    // Stimulus and expectations
    point_item_t pending_points[$];
    scan_pick_t  scan_expect[$];
    point_item_t tx_item;
    scan_pick_t  want;

    // Shadow copy of the point set and the row length register
    gcso_pkg::coord_t   set_x [gcso_pkg::MAX_POINTS];
    gcso_pkg::coord_t   set_y [gcso_pkg::MAX_POINTS];
    int                 set_count    = 0;
    gcso_pkg::row_len_t scan_row_len = gcso_pkg::row_len_t'(gcso_pkg::ROW_LEN_RESET);

    // Flow control
    bit point_accepted = 1'b0;
    int src_gap        = 0;
    int rx_gap         = 0;
    bit idle_on        = 1'b1;
    bit hold_arm       = 1'b0;
    bit long_hold      = 1'b0;

    int mismatches  = 0;
    int cycle_count = 0;

    logic [gcso_pkg::INPUT_COORD_BITS-1:0] corner_vals [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    grid_corner_scan_order u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_point     (last_point),
        .order_valid    (order_valid),
        .order_stall    (order_stall),
        .order_index    (order_index),
        .last_index     (last_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scan order prediction
    // ------------------------------------------------------------------------
    // Each accepted item is stored while there is room; a full set silently
    // drops the point but a closing flag still triggers the ordering. The
    // ordering repeatedly takes the free point with the smallest x (lowest
    // index on a tie). Within a row, points at or below the previous pick's
    // y are masked; if everything is masked the lowest free index is used.
    function automatic void predict_point(gcso_pkg::coord_t x, gcso_pkg::coord_t y,
                                          logic closes);
        bit               used [gcso_pkg::MAX_POINTS];
        gcso_pkg::coord_t bound;
        int unsigned      row_pos;
        int unsigned      step;
        int               pick;
        int               first_free;
        bit               found;
        bit               any_free;
        scan_pick_t       r;

        if (set_count < gcso_pkg::MAX_POINTS)
        begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_count++;
        end
        if (closes)
        begin
            foreach (used[i])
                used[i] = 1'b0;
            bound   = '0;
            row_pos = 0;
            for (int k = 0; k < set_count; k++)
            begin
                found      = 1'b0;
                any_free   = 1'b0;
                pick       = 0;
                first_free = 0;
                for (int i = 0; i < set_count; i++)
                begin
                    if (used[i])
                        continue;
                    if (!any_free)
                    begin
                        first_free = i;
                        any_free   = 1'b1;
                    end
                    // row mask only applies after the first pick of a row
                    if (row_pos > 0 && set_y[i] <= bound)
                        continue;
                    if (!found || set_x[i] < set_x[pick])
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    pick = first_free;
                used[pick] = 1'b1;
                bound      = set_y[pick];
                // row counter wraps at the row length, or at 16 at the latest
                step = row_pos + 1;
                if (step >= scan_row_len || step >= gcso_pkg::ROW_POS_LIMIT)
                    step = 0;
                row_pos = step;
                r.idx    = gcso_pkg::order_index_t'(pick);
                r.closes = (k + 1 == set_count);
                scan_expect = {scan_expect, r};
            end
            set_count = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Input side: accept tracking and the point driver
    // ------------------------------------------------------------------------
    // Handshakes are seen at the rising edge; the driver acts on them at the
    // following falling edge, so nothing here races the block.
    always @(posedge clk)
    begin
        point_accepted <= rst_n && point_valid && !point_stall;
        if (rst_n && point_valid && !point_stall)
            predict_point(gcso_pkg::coord_t'(point_x), gcso_pkg::coord_t'(point_y),
                          last_point);
    end

    // Holds an item until it is taken, then either idles for a burst or
    // offers the next queued item straight away.
    always @(negedge clk)
    begin
        if (!rst_n)
            point_valid <= 1'b0;
        else if (!point_valid || point_accepted)
        begin
            if (src_gap > 0)
            begin
                src_gap     <= src_gap - 1;
                point_valid <= 1'b0;
            end
            else if (pending_points.size() > 0)
            begin
                tx_item      = pending_points.pop_front();
                point_x     <= tx_item.x;
                point_y     <= tx_item.y;
                last_point  <= tx_item.last;
                point_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    src_gap <= $urandom_range(1, 6);
            end
            else
                point_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: stall generator and result checker
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            order_stall <= 1'b0;
        else if (long_hold)
            order_stall <= 1'b1;
        else if (rx_gap > 0)
        begin
            rx_gap      <= rx_gap - 1;
            order_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_gap      <= $urandom_range(0, 5);
            order_stall <= 1'b1;
        end
        else
            order_stall <= 1'b0;
    end

    // Long hold-off at the output: the sender keeps offering items, so the
    // output register, the back end and the input queue all back up.
    initial
    begin : output_hold_off
        wait (hold_arm);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && order_valid && !order_stall)
        begin
            if (scan_expect.size() == 0)
                report_mismatch($sformatf("unexpected item, index %0d last %0b",
                                          order_index, last_index));
            else
            begin
                want = scan_expect.pop_front();
                if (order_index !== want.idx)
                    report_mismatch($sformatf("order_index %0d, expected %0d",
                                              order_index, want.idx));
                if (last_index !== want.closes)
                    report_mismatch($sformatf("last_index %0b, expected %0b (index %0d)",
                                              last_index, want.closes, want.idx));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_point(logic [31:0] x, logic [31:0] y, logic last);
        point_item_t p;
        p.x    = x;
        p.y    = y;
        p.last = last;
        pending_points = {pending_points, p};
    endfunction

    // Coordinates mix full-range values with a coarse lattice, so that equal
    // x values and masked rows turn up often.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: pick_coord = $urandom();
            1: pick_coord = ($urandom_range(0, 7) << 16) - 32'h0004_0000;
            2: pick_coord = ($urandom_range(0, 3) << 16) + $urandom_range(0, 3);
            default: pick_coord = corner_vals[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic void add_set(int n);
        for (int j = 0; j < n; j++)
            queue_point(pick_coord(), pick_coord(), j == n - 1);
    endfunction

    // A phase of whole sets, mostly small ones.
    function automatic void add_phase(int budget);
        int n;
        int sz;
        n = 0;
        while (n < budget)
        begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            if (sz > budget - n)
                sz = budget - n;
            add_set(sz);
            n += sz;
        end
    endfunction

    // Waits until every queued item is in and every result is out.
    task automatic settle();
        while (pending_points.size() != 0 || point_valid || scan_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic set_row_length(input int unsigned value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= gcso_pkg::row_len_t'(value);
        scan_row_len    = gcso_pkg::row_len_t'(value);
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        point_valid    = 1'b0;
        point_x        = '0;
        point_y        = '0;
        last_point     = 1'b0;
        order_stall    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset row length of 8 first.
        // lone point at the extremes
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // equal x everywhere: lowest index wins, rising y keeps all unmasked
        queue_point(32'h0005_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h0005_0000, 32'h0001_0000, 1'b0);
        queue_point(32'h0005_0000, 32'h0002_0000, 1'b1);
        // falling y: after the first pick every free point is masked
        queue_point(32'h0000_0000, 32'h000A_0000, 1'b0);
        queue_point(32'h0001_0000, 32'h0005_0000, 1'b0);
        queue_point(32'h0002_0000, 32'h0003_0000, 1'b1);
        settle();

        set_row_length(16);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        settle();

        // row length 0 and 1 never mask: same falling-y set under both
        set_row_length(0);
        queue_point(32'h0000_0000, 32'h000A_0000, 1'b0);
        queue_point(32'h0002_0000, 32'h0005_0000, 1'b0);
        queue_point(32'h0001_0000, 32'h0003_0000, 1'b1);
        settle();
        set_row_length(1);
        queue_point(32'h0000_0000, 32'h000A_0000, 1'b0);
        queue_point(32'h0002_0000, 32'h0005_0000, 1'b0);
        queue_point(32'h0001_0000, 32'h0003_0000, 1'b1);
        settle();

        // Random: shortest rows
        set_row_length(2);
        add_phase(PHASE_ITEMS);
        settle();

        // Longest rows, with the output held off while items keep coming
        set_row_length(16);
        hold_arm = 1'b1;
        add_phase(PHASE_ITEMS);
        settle();

        // Store full: 64 points kept, two dropped, closing item dropped too
        set_row_length($urandom_range(2, 16));
        add_set(gcso_pkg::MAX_POINTS + 3);
        settle();

        set_row_length(1);
        add_phase(PHASE_ITEMS);
        settle();

        // above 16 behaves as 16
        set_row_length(31);
        add_phase(PHASE_ITEMS);
        settle();

        set_row_length($urandom_range(0, 31));
        add_phase(PHASE_ITEMS);
        settle();

        // Last part runs at full rate on both sides
        idle_on = 1'b0;
        set_row_length($urandom_range(2, 16));
        add_phase(PHASE_ITEMS);
        settle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
